// ===== src/mbrfb_pkg.sv =====
// modbus rtu request frame builder: shared constants, types and functions
// crc-16 byte step, crc byte-order transform and data word selection
// no dependencies
package mbrfb_pkg;

  localparam int FRAME_BYTES   = 8;
  localparam int PAYLOAD_BYTES = 6;
  localparam int IDX_W         = $clog2(FRAME_BYTES);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // request type codes (function code minus one)
  localparam logic [2:0] REQ_RD_COILS    = 3'd0;
  localparam logic [2:0] REQ_RD_DISCRETE = 3'd1;
  localparam logic [2:0] REQ_RD_HOLDING  = 3'd2;
  localparam logic [2:0] REQ_RD_INPUT    = 3'd3;
  localparam logic [2:0] REQ_WR_COIL     = 3'd4;
  localparam logic [2:0] REQ_WR_REG      = 3'd5;

  // crc byte-order codes
  localparam logic [1:0] ORD_NONE   = 2'd0;
  localparam logic [1:0] ORD_SWAP   = 2'd1;
  localparam logic [1:0] ORD_SHUF_A = 2'd2;
  localparam logic [1:0] ORD_SHUF_B = 2'd3;

  // byte positions within the frame
  localparam logic [IDX_W-1:0] POS_SLAVE   = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_FUNC    = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_ADDR_HI = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_ADDR_LO = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_WORD_HI = IDX_W'(4);
  localparam logic [IDX_W-1:0] POS_WORD_LO = IDX_W'(5);
  localparam logic [IDX_W-1:0] POS_CRC_HI  = IDX_W'(PAYLOAD_BYTES);
  localparam logic [IDX_W-1:0] POS_LAST    = IDX_W'(FRAME_BYTES - 1);

  typedef struct packed {
    logic init;
    logic update;
  } crc_ctl_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_transform(input logic [15:0] crc, input logic [1:0] mode);
    logic [15:0] r;
    case (mode)
      ORD_NONE:   r = crc;
      ORD_SWAP:   r = {crc[7:0], crc[15:8]};
      ORD_SHUF_A: r = {crc[11:8], crc[15:12], 4'h0, crc[7:4]};
      default:    r = {4'h0, crc[7:4], crc[11:8], crc[15:12]};
    endcase
    return r;
  endfunction

  function automatic logic [15:0] data_word(input logic [2:0] req_type,
                                            input logic [15:0] value,
                                            input logic coil_on);
    logic [15:0] w;
    case (req_type)
      REQ_RD_HOLDING: w = {8'h00, value[7:0]};
      REQ_RD_INPUT:   w = {8'h00, value[7:0]};
      REQ_WR_COIL:    w = coil_on ? 16'hFF00 : 16'h0000;
      default:        w = value;
    endcase
    return w;
  endfunction

endpackage

// ===== src/modbus_request_frame_builder.sv =====
// modbus rtu request frame builder top level: request register, byte serializer,
// output register and crc order register; depends on mbrfb_pkg and mbrfb_crc
//
//   channel | handshake            | payload
//   in      | in_valid / in_stall  | req_type, unit_id, address, value, coil_on
//   out     | out_valid / out_stall| frame_byte, last_byte
//   cfg     | cfg_valid / cfg_ready| crc_order
//
// each request gives eight beats, one per cycle without stall.
// the crc advances one byte per emitted payload byte.
// the next request is taken in the cycle the last byte enters the output register.
// request types 6 and 7 are taken and give no beat.
// reset is synchronous; crc_order resets to byte swap. out_stall holds the output beat.
module modbus_request_frame_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_unit_id,
  input  logic [15:0] in_address,
  input  logic [15:0] in_value,
  input  logic        in_coil_on,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte,
  output logic        out_last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_crc_order
);

  localparam int IDX_W = mbrfb_pkg::IDX_W;

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]       crc_order_r;
  logic             out_valid_r;
  logic [7:0]       out_frame_byte_r;
  logic             out_last_byte_r;
  logic [7:0]       slave_r;
  logic [7:0]       func_r;
  logic [15:0]      addr_r;
  logic [15:0]      word_r;

  logic                out_free, load, load_last, in_acc, req_ok;
  logic [7:0]          byte_sel;
  logic [15:0]         crc_q, crc_tx;
  mbrfb_pkg::crc_ctl_t crc_ctl;

  assign out_free  = !out_valid_r || !out_stall;
  assign load      = busy_r && out_free;
  assign load_last = load && (idx_r == mbrfb_pkg::POS_LAST);
  assign in_stall  = busy_r && !load_last;
  assign in_acc    = in_valid && !in_stall;
  assign req_ok    = in_req_type <= mbrfb_pkg::REQ_WR_REG;
  assign cfg_ready = 1'b1;

  // init in the upper bit, update in the lower bit
  assign crc_ctl = {in_acc && req_ok, load && (idx_r < mbrfb_pkg::POS_CRC_HI)};

  mbrfb_crc u_crc (
    .clk       (clk),
    .ctl       (crc_ctl),
    .data_byte (byte_sel),
    .crc       (crc_q)
  );

  assign crc_tx = mbrfb_pkg::crc_transform(crc_q, crc_order_r);

  always_comb begin
    case (idx_r)
      mbrfb_pkg::POS_SLAVE:   byte_sel = slave_r;
      mbrfb_pkg::POS_FUNC:    byte_sel = func_r;
      mbrfb_pkg::POS_ADDR_HI: byte_sel = addr_r[15:8];
      mbrfb_pkg::POS_ADDR_LO: byte_sel = addr_r[7:0];
      mbrfb_pkg::POS_WORD_HI: byte_sel = word_r[15:8];
      mbrfb_pkg::POS_WORD_LO: byte_sel = word_r[7:0];
      mbrfb_pkg::POS_CRC_HI:  byte_sel = crc_tx[15:8];
      default:                byte_sel = crc_tx[7:0];
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    if (load_last) begin
      busy_nxt = 1'b0;
    end
    if (in_acc && req_ok) begin
      busy_nxt = 1'b1;
      idx_nxt  = mbrfb_pkg::POS_SLAVE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= mbrfb_pkg::POS_SLAVE;
      out_valid_r <= 1'b0;
      crc_order_r <= mbrfb_pkg::ORD_SWAP;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      if (cfg_valid && cfg_ready) begin
        crc_order_r <= cfg_crc_order;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc && req_ok) begin
      slave_r <= in_unit_id;
      func_r  <= {5'b00000, in_req_type} + 8'd1;
      addr_r  <= in_address;
      word_r  <= mbrfb_pkg::data_word(in_req_type, in_value, in_coil_on);
    end
    if (load) begin
      out_frame_byte_r <= byte_sel;
      out_last_byte_r  <= (idx_r == mbrfb_pkg::POS_LAST);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_frame_byte_r;
  assign out_last_byte  = out_last_byte_r;

  // a new request only enters an idle serializer or one loading its last beat
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!busy_r || load_last))
    else $error("request accepted while frame in progress");

  // the crc never advances on its own output bytes
  a_crc_payload_only: assert property (@(posedge clk) disable iff (!rst_n)
    crc_ctl.update |-> !crc_ctl.init && (idx_r < mbrfb_pkg::POS_CRC_HI))
    else $error("crc updated outside payload bytes");

  // loading the final position shows a flagged last beat next cycle
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    load_last |=> (out_valid && out_last_byte))
    else $error("last beat not flagged");

  // a flagged last beat leaves the serializer free unless a new request came in
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load_last && !(in_acc && req_ok)) |=> !busy_r)
    else $error("serializer busy after last beat");

endmodule

// ===== src/mbrfb_crc.sv =====
// running crc-16 register, one frame byte per update
// depends on mbrfb_pkg
module mbrfb_crc (
  input  logic                clk,
  input  mbrfb_pkg::crc_ctl_t ctl,
  input  logic [7:0]          data_byte,
  output logic [15:0]         crc
);

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;

  always_comb begin
    crc_nxt = crc_r;
    if (ctl.init) begin
      crc_nxt = mbrfb_pkg::CRC_INIT;
    end else if (ctl.update) begin
      crc_nxt = mbrfb_pkg::crc16_byte(crc_r, data_byte);
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  assign crc = crc_r;

endmodule
